// ===== rtl/core/signed_unsigned_divider_64_macros.svh =====
// Assertion macros shared by the divider RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SIGNED_UNSIGNED_DIVIDER_64_MACROS_SVH
`define SIGNED_UNSIGNED_DIVIDER_64_MACROS_SVH

`ifndef SYNTHESIS

// Condition a implies condition b in the same cycle.
`define SUDIV_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("divider check failed");

// Condition a implies condition b in the next cycle.
`define SUDIV_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("divider check failed");

`else

`define SUDIV_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define SUDIV_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

// ===== rtl/core/sudiv_pkg.sv =====
// Shared constants and types of the signed/unsigned divider.
// No dependencies; used by every module in rtl/core.
package sudiv_pkg;

	// Width of each operand and result field on the ports.
	localparam int FIELD_W = 64;
	localparam int TDATA_W = 2 * FIELD_W;

	// Default operand width used inside the datapath.
	localparam int DATA_WIDTH_DEF = 64;

	// Division kind carried on tuser.
	localparam logic KIND_UNSIGNED = 1'b0;
	localparam logic KIND_SIGNED   = 1'b1;

	// Sign and special-case flags that travel with an item down the pipeline.
	typedef struct packed {
		logic q_neg;
		logic r_neg;
		logic den_zero;
	} sudiv_flags_t;

endpackage

// ===== rtl/core/sudiv_prep.sv =====
// Input stage of the divider: masks the operands, takes magnitudes in signed
// mode and records the sign and zero-divisor flags. Depends on sudiv_pkg.
module sudiv_prep #(
	parameter int DATA_WIDTH = sudiv_pkg::DATA_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_in,
	input  logic                        kind,
	input  logic [sudiv_pkg::FIELD_W-1:0] dividend,
	input  logic [sudiv_pkg::FIELD_W-1:0] divisor,
	output logic                        vld_s1,
	output logic [DATA_WIDTH-1:0]       num_s1,
	output logic [DATA_WIDTH-1:0]       den_s1,
	output sudiv_pkg::sudiv_flags_t     flags_s1
);

	logic [DATA_WIDTH-1:0] a;
	logic [DATA_WIDTH-1:0] b;
	logic                  a_neg;
	logic                  b_neg;

	assign a     = dividend[DATA_WIDTH-1:0];
	assign b     = divisor[DATA_WIDTH-1:0];
	assign a_neg = (kind == sudiv_pkg::KIND_SIGNED) && a[DATA_WIDTH-1];
	assign b_neg = (kind == sudiv_pkg::KIND_SIGNED) && b[DATA_WIDTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1            <= a_neg ? (~a + 1'b1) : a;
			den_s1            <= b_neg ? (~b + 1'b1) : b;
			flags_s1.q_neg    <= a_neg ^ b_neg;
			flags_s1.r_neg    <= a_neg;
			flags_s1.den_zero <= (b == '0);
		end
	end

endmodule

// ===== rtl/core/sudiv_step.sv =====
// One restoring division stage: develops one quotient bit per item.
// Depends on sudiv_pkg and the assertion macro header.
`include "signed_unsigned_divider_64_macros.svh"

module sudiv_step #(
	parameter int DATA_WIDTH = sudiv_pkg::DATA_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_in,
	input  logic [DATA_WIDTH-1:0]   rem_in,
	input  logic [DATA_WIDTH-1:0]   nq_in,
	input  logic [DATA_WIDTH-1:0]   den_in,
	input  sudiv_pkg::sudiv_flags_t flags_in,
	output logic                    vld_s1,
	output logic [DATA_WIDTH-1:0]   rem_s1,
	output logic [DATA_WIDTH-1:0]   nq_s1,
	output logic [DATA_WIDTH-1:0]   den_s1,
	output sudiv_pkg::sudiv_flags_t flags_s1
);

	// nq holds the unused dividend bits at the top and the quotient bits
	// developed so far at the bottom; it shifts left by one per stage.
	logic [DATA_WIDTH:0]   rem_ext;
	logic [DATA_WIDTH+1:0] diff;
	logic                  q_bit;

	assign rem_ext = {rem_in, nq_in[DATA_WIDTH-1]};
	assign diff    = {1'b0, rem_ext} - {2'b00, den_in};
	assign q_bit   = ~diff[DATA_WIDTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1   <= q_bit ? diff[DATA_WIDTH-1:0] : rem_ext[DATA_WIDTH-1:0];
			nq_s1    <= {nq_in[DATA_WIDTH-2:0], q_bit};
			den_s1   <= den_in;
			flags_s1 <= flags_in;
		end
	end

	// The partial remainder of a restoring divider never reaches the divisor.
	`SUDIV_ASSERT_IMPLIES(a_rem_below_den, clk, arst_n, vld_s1 && (den_s1 != '0), rem_s1 < den_s1)

endmodule

// ===== rtl/core/sudiv_fix.sv =====
// Output stage of the divider: restores the signs of quotient and remainder
// and forces a zero quotient for a zero divisor. Depends on sudiv_pkg.
module sudiv_fix #(
	parameter int DATA_WIDTH = sudiv_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  logic [DATA_WIDTH-1:0]         rem_in,
	input  logic [DATA_WIDTH-1:0]         quo_in,
	input  sudiv_pkg::sudiv_flags_t       flags_in,
	output logic                          vld_s1,
	output logic [sudiv_pkg::TDATA_W-1:0] res_s1
);

	logic [DATA_WIDTH-1:0] quo;
	logic [DATA_WIDTH-1:0] rem;

	// With a zero divisor the remainder path already yields the dividend.
	always_comb begin
		if (flags_in.den_zero) begin
			quo = '0;
		end else if (flags_in.q_neg) begin
			quo = ~quo_in + 1'b1;
		end else begin
			quo = quo_in;
		end
		rem = flags_in.r_neg ? (~rem_in + 1'b1) : rem_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1 <= {sudiv_pkg::FIELD_W'(rem), sudiv_pkg::FIELD_W'(quo)};
		end
	end

endmodule

// ===== rtl/core/sudiv_skid.sv =====
// Output register with a one-entry skid buffer; its fullness stalls the
// divider pipeline. Depends on sudiv_pkg and the assertion macro header.
`include "signed_unsigned_divider_64_macros.svh"

module sudiv_skid (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [sudiv_pkg::TDATA_W-1:0] in_data,
	output logic                          en,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sudiv_pkg::TDATA_W-1:0] out_data
);

	logic                          out_valid_q;
	logic                          skid_valid_q;
	logic [sudiv_pkg::TDATA_W-1:0] out_data_q;
	logic [sudiv_pkg::TDATA_W-1:0] skid_data_q;
	logic                          out_free;
	logic                          push;

	// The pipeline only moves while the skid entry is empty, so at most one
	// item can arrive while the output is held.
	assign en       = ~skid_valid_q;
	assign out_free = ~out_valid_q | out_ready;
	assign push     = en & in_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q | push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (push) begin
			skid_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`SUDIV_ASSERT_IMPLIES(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`SUDIV_ASSERT_NEXT(a_skid_catches, clk, arst_n, push && out_valid_q && !out_ready, skid_valid_q)
	`SUDIV_ASSERT_NEXT(a_skid_drains, clk, arst_n, skid_valid_q && out_ready, !skid_valid_q && out_valid_q)

endmodule

// ===== rtl/core/signed_unsigned_divider_64.sv =====
// Top level of the pipelined signed/unsigned divider.
// Depends on sudiv_pkg, sudiv_prep, sudiv_step, sudiv_fix and sudiv_skid.
//
// Fully pipelined restoring divider: it accepts one item per cycle while
// s_tready is high and returns quotient and remainder through one input stage
// that takes magnitudes, one stage per quotient bit, one sign-fix stage and
// the output register. Signed division truncates toward zero and the
// remainder follows the dividend's sign; a zero divisor yields a zero
// quotient and the dividend as remainder, and the most negative value over
// minus one wraps. Operand bits at DATA_WIDTH and above are ignored and the
// result fields are zero-extended. s_tready drops only when the one-entry
// skid buffer is full, which happens when an item arrives while the output
// is held.
module signed_unsigned_divider_64 #(
	parameter int DATA_WIDTH = sudiv_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sudiv_pkg::TDATA_W-1:0] s_tdata,  // dividend[63:0], divisor[127:64]
	input  logic [0:0]                    s_tuser,  // kind[0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sudiv_pkg::TDATA_W-1:0] m_tdata   // quotient[63:0], remainder[127:64]
);

	logic                    en;
	logic                    vld_p   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0]   rem_p   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0]   nq_p    [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0]   den_p   [DATA_WIDTH+1];
	sudiv_pkg::sudiv_flags_t flags_p [DATA_WIDTH+1];

	logic                          fix_vld;
	logic [sudiv_pkg::TDATA_W-1:0] fix_res;

	assign s_tready = en;
	assign rem_p[0] = '0;

	sudiv_prep #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (s_tvalid),
		.kind     (s_tuser[0]),
		.dividend (s_tdata[sudiv_pkg::FIELD_W-1:0]),
		.divisor  (s_tdata[sudiv_pkg::TDATA_W-1:sudiv_pkg::FIELD_W]),
		.vld_s1   (vld_p[0]),
		.num_s1   (nq_p[0]),
		.den_s1   (den_p[0]),
		.flags_s1 (flags_p[0])
	);

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
		sudiv_step #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vld_in   (vld_p[i]),
			.rem_in   (rem_p[i]),
			.nq_in    (nq_p[i]),
			.den_in   (den_p[i]),
			.flags_in (flags_p[i]),
			.vld_s1   (vld_p[i+1]),
			.rem_s1   (rem_p[i+1]),
			.nq_s1    (nq_p[i+1]),
			.den_s1   (den_p[i+1]),
			.flags_s1 (flags_p[i+1])
		);
	end

	sudiv_fix #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_fix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_p[DATA_WIDTH]),
		.rem_in   (rem_p[DATA_WIDTH]),
		.quo_in   (nq_p[DATA_WIDTH]),
		.flags_in (flags_p[DATA_WIDTH]),
		.vld_s1   (fix_vld),
		.res_s1   (fix_res)
	);

	sudiv_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (fix_vld),
		.in_data   (fix_res),
		.en        (en),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
